FILE: rtl/quoted_word_splitter_defines.svh
// ----------------------------------------------------------------------------
// Quoted word splitter assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_WORD_SPLITTER_DEFINES_SVH
`define QUOTED_WORD_SPLITTER_DEFINES_SVH

// same-cycle implication
`define QWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("quoted_word_splitter: assertion failed");

// next-cycle implication
`define QWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("quoted_word_splitter: assertion failed");

`endif

FILE: rtl/qws_pkg.sv
// ----------------------------------------------------------------------------
// Quoted word splitter package
// Widths, character codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package qws_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int LEN_BITS     = 16;
    localparam int LIMIT_BITS   = 16;
    localparam int CMP_BITS     = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int M_TDATA_BITS = 32;
    localparam int M_PAD_BITS   = M_TDATA_BITS - 8 - LEN_BITS - 1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(255);

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_NOWORD = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          word_byte;
        logic [LEN_BITS-1:0] word_length;
        logic                line_end;
        logic                last;
    } result_t;

endpackage

FILE: rtl/quoted_word_splitter.sv
// ----------------------------------------------------------------------------
// Quoted word splitter
// Cuts a byte stream of text lines into words, one byte per request.
//
// s_ channel: one text byte per request in s_tdata.
// m_ channel: word bytes, word ends and empty line ends; m_tuser holds the
//   kind, m_tlast marks the final result caused by one input byte.
// cfg_wr_en / cfg_wr_data: write the kept-byte limit; write only while idle.
// A byte's first result is registered and offered in the cycle after it is taken.
// Throughput: one byte per cycle unless stalled. A kept backslash escape followed
//   by a line end gives two results; the second waits in a hold register and
//   input is stalled while it drains. Bytes dropped past the limit and blanks
//   between words give no result.
// s_tready follows m_tready combinationally if the result register alone is full.
// Reset: phase goes to between-words, escape and count clear, limit is 255,
//   both result registers empty.
// Receiver stall: the result register holds; a new byte is taken only when
//   the result register is empty or draining and the hold register is empty.
// ----------------------------------------------------------------------------
`include "quoted_word_splitter_defines.svh"

module quoted_word_splitter
    import qws_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [LIMIT_BITS-1:0]   cfg_wr_data,   // kept_limit
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,       // text_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,       // word_byte, word_length, line_end, pad
    output logic [1:0]              m_tuser,       // kind
    output logic                    m_tlast        // last
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_QUOTED = 2'd2
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  esc_reg, esc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg, pend_next;

    logic                  fire;
    logic                  is_end, is_blank;
    logic                  kp_req, kp_ok, fin_req, fin_le, fin_word, fin_emit;
    logic [7:0]            kp_byte;
    logic [COUNT_BITS-1:0] cnt_in, cnt_k;
    result_t               kp_res, fin_res, r0, r1;
    logic [1:0]            n_res;

    assign s_tready = !pend_valid_reg && (!out_valid_reg || m_tready);
    assign fire     = s_tvalid && s_tready;
    assign is_end   = (s_tdata == CH_NUL) || (s_tdata == CH_LF);
    assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        cnt_in     = count_reg;
        kp_req     = 1'b0;
        kp_byte    = s_tdata;
        fin_req    = 1'b0;
        fin_le     = 1'b0;
        if (phase_reg != PH_PLAIN && phase_reg != PH_QUOTED) begin
            phase_next = PH_SKIP;
            esc_next   = 1'b0;
            cnt_in     = '0;
            if (is_end) begin
                fin_req = 1'b1;
                fin_le  = 1'b1;
            end else if (is_blank) begin
                phase_next = PH_SKIP;
            end else if (s_tdata == CH_QUOTE) begin
                phase_next = PH_QUOTED;
            end else if (s_tdata == CH_BSLASH) begin
                phase_next = PH_PLAIN;
                esc_next   = 1'b1;
            end else begin
                phase_next = PH_PLAIN;
                kp_req     = 1'b1;
            end
        end else if (esc_reg) begin
            esc_next = 1'b0;
            kp_req   = 1'b1;
            if (is_end) begin
                kp_byte = CH_BSLASH;
                fin_req = 1'b1;
                fin_le  = 1'b1;
            end
        end else if (is_end) begin
            fin_req = 1'b1;
            fin_le  = 1'b1;
        end else if (s_tdata == CH_BSLASH) begin
            esc_next = 1'b1;
        end else if (phase_reg == PH_PLAIN && is_blank) begin
            fin_req = 1'b1;
        end else if (phase_reg == PH_QUOTED && s_tdata == CH_QUOTE) begin
            fin_req = 1'b1;
        end else begin
            kp_req = 1'b1;
        end

        kp_ok    = kp_req && (CMP_BITS'(cnt_in) < CMP_BITS'(limit_reg))
                   && (cnt_in != {COUNT_BITS{1'b1}});
        cnt_k    = cnt_in + COUNT_BITS'(kp_ok);
        fin_word = (phase_reg == PH_QUOTED) || (cnt_k != '0);
        fin_emit = fin_req && (fin_word || fin_le);

        if (fin_req) begin
            phase_next = PH_SKIP;
            esc_next   = 1'b0;
            count_next = '0;
        end else begin
            count_next = cnt_k;
        end

        kp_res.kind        = KIND_BYTE;
        kp_res.word_byte   = kp_byte;
        kp_res.word_length = '0;
        kp_res.line_end    = 1'b0;
        kp_res.last        = !fin_emit;

        fin_res.kind        = fin_word ? KIND_END : KIND_NOWORD;
        fin_res.word_byte   = '0;
        fin_res.word_length = fin_word ? LEN_BITS'(cnt_k) : '0;
        fin_res.line_end    = fin_le;
        fin_res.last        = 1'b1;

        if (kp_ok) begin
            r0    = kp_res;
            r1    = fin_res;
            n_res = fin_emit ? 2'd2 : 2'd1;
        end else begin
            r0    = fin_res;
            r1    = fin_res;
            n_res = fin_emit ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (fire) begin
            out_valid_next  = (n_res != 2'd0);
            out_next        = r0;
            pend_valid_next = (n_res == 2'd2);
            pend_next       = r1;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SKIP;
            esc_reg        <= 1'b0;
            count_reg      <= '0;
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                count_reg <= count_next;
            end
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_BITS{1'b0}}, out_reg.line_end, out_reg.word_length,
                       out_reg.word_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    `QWS_ASSERT_NOW(a_pend_needs_out, pend_valid_reg, out_valid_reg)
    `QWS_ASSERT_NOW(a_pend_is_word_end, pend_valid_reg,
        pend_reg.kind == KIND_END && pend_reg.last && pend_reg.line_end)
    `QWS_ASSERT_NOW(a_skip_count_zero, phase_reg == PH_SKIP, count_reg == '0 && !esc_reg)
    `QWS_ASSERT_NOW(a_noword_closes_line, m_tvalid && m_tuser == KIND_NOWORD,
        m_tlast && out_reg.line_end && out_reg.word_length == '0)
    `QWS_ASSERT_NEXT(a_stall_blocks_input, pend_valid_reg && !m_tready,
        pend_valid_reg && !s_tready)

endmodule

FILE: verif/tb_quoted_word_splitter.sv
// ----------------------------------------------------------------------------
// Quoted word splitter testbench
// Feeds text lines byte by byte: a few hand-written lines first, then random
// lines made mostly of plain words, quoted words, blanks and escapes, with
// some noise. Runs under several kept-byte limits (0, 1, 65535 among them).
// A word-splitting predictor built into the scoreboard works out the results
// of every accepted byte. Each returned result is checked against them in
// order. Both sides idle at random, and the receiver once holds off long
// enough to stall the input.
// ----------------------------------------------------------------------------
module tb_quoted_word_splitter
    import qws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 30;
    localparam int RANDOM_BYTES_PER_PHASE = 80;

    typedef enum logic [1:0] {
        WS_BETWEEN,
        WS_PLAIN,
        WS_QUOTED
    } split_phase_t;

    class split_tracker;
        logic [LIMIT_BITS-1:0] kept_limit;
        split_phase_t          phase;
        bit                    escaped;
        logic [COUNT_BITS-1:0] kept;
        result_t               expected_q[$];
        int                    errors;
        int                    checked;

        function new();
            kept_limit = LIMIT_RESET;
            phase      = WS_BETWEEN;
            escaped    = 1'b0;
            kept       = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            kept_limit = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void emit(kind_t k, logic [7:0] b, logic [LEN_BITS-1:0] len, logic le);
            result_t r;
            r.kind        = k;
            r.word_byte   = b;
            r.word_length = len;
            r.line_end    = le;
            r.last        = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void keep_byte(logic [7:0] b);
            if (CMP_BITS'(kept) < CMP_BITS'(kept_limit) && kept != '1) begin
                emit(KIND_BYTE, b, '0, 1'b0);
                kept++;
            end
        endfunction

        function void close_word(logic le);
            if (phase == WS_QUOTED || kept != '0)
                emit(KIND_END, 8'd0, LEN_BITS'(kept), le);
            else if (le)
                emit(KIND_NOWORD, 8'd0, '0, 1'b1);
            phase   = WS_BETWEEN;
            kept    = '0;
            escaped = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b);
            int      start_n;
            bit      ends;
            bit      blank;
            result_t r;
            start_n = expected_q.size();
            ends    = (b == CH_NUL || b == CH_LF);
            blank   = (b == CH_SPACE || b == CH_TAB);
            if (phase == WS_BETWEEN) begin
                escaped = 1'b0;
                if (ends) begin
                    emit(KIND_NOWORD, 8'd0, '0, 1'b1);
                end else if (blank) begin
                end else if (b == CH_QUOTE) begin
                    phase = WS_QUOTED;
                    kept  = '0;
                end else if (b == CH_BSLASH) begin
                    phase   = WS_PLAIN;
                    kept    = '0;
                    escaped = 1'b1;
                end else begin
                    phase = WS_PLAIN;
                    kept  = '0;
                    keep_byte(b);
                end
            end else if (escaped) begin
                escaped = 1'b0;
                if (ends) begin
                    keep_byte(CH_BSLASH);
                    close_word(1'b1);
                end else begin
                    keep_byte(b);
                end
            end else if (ends) begin
                close_word(1'b1);
            end else if (b == CH_BSLASH) begin
                escaped = 1'b1;
            end else if (phase == WS_PLAIN && blank) begin
                close_word(1'b0);
            end else if (phase == WS_QUOTED && b == CH_QUOTE) begin
                close_word(1'b0);
            end else begin
                keep_byte(b);
            end
            if (expected_q.size() > start_n) begin
                r      = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] wbyte,
                                   logic [LEN_BITS-1:0] wlen, logic le, logic last,
                                   logic [M_PAD_BITS-1:0] pad);
            result_t want;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                             $time, kind, wbyte);
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(kind));
            compare_field("word_byte", 32'(want.word_byte), 32'(wbyte));
            compare_field("word_length", 32'(want.word_length), 32'(wlen));
            compare_field("line_end", 32'(want.line_end), 32'(le));
            compare_field("last", 32'(want.last), 32'(last));
            compare_field("pad", 32'd0, 32'(pad));
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [LIMIT_BITS-1:0]   cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;

    split_tracker sb = new();

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_len = 0;
    int bytes_sent = 0;
    int limits_used = 0;

    quoted_word_splitter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[7:0], m_tdata[8 +: LEN_BITS],
                                m_tdata[8 + LEN_BITS], m_tlast,
                                m_tdata[M_TDATA_BITS-1 -: M_PAD_BITS]);
            if (s_tvalid && s_tready)
                sb.take_byte(s_tdata);
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // receiver: one assignment per falling edge
    initial begin
        int n;
        forever begin
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
                repeat (n) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                n = rx_steady ? 0 : idle_len();
                repeat (n) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end
            @(negedge aclk);
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(value);
        limits_used++;
    endtask

    function automatic logic [7:0] pick_word_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(97, 122));
        do
            c = 8'($urandom_range(33, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic send_random_line();
        int r;
        int nwords;
        bit unclosed;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) push_byte(pick_blank());
        nwords   = $urandom_range(0, 4);
        unclosed = 1'b0;
        for (int w = 0; w < nwords; w++) begin
            if (w > 0)
                repeat ($urandom_range(1, 2)) push_byte(pick_blank());
            if ($urandom_range(0, 2) == 0) begin
                push_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    r = $urandom_range(0, 99);
                    if (r < 12) begin
                        push_byte(CH_BSLASH);
                        push_byte($urandom_range(0, 1) ? CH_QUOTE
                                                       : 8'($urandom_range(0, 255)));
                    end else if (r < 30) begin
                        push_byte(pick_blank());
                    end else begin
                        push_byte(pick_word_char());
                    end
                end
                if (w == nwords - 1 && $urandom_range(0, 9) == 0)
                    unclosed = 1'b1;
                else
                    push_byte(CH_QUOTE);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(CH_BSLASH);
                    push_byte($urandom_range(0, 1) ? CH_QUOTE : pick_blank());
                end
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        push_byte(CH_QUOTE);
                    end else if (r < 20) begin
                        push_byte(CH_BSLASH);
                        push_byte(8'($urandom_range(0, 255)));
                    end else begin
                        push_byte(pick_word_char());
                    end
                end
            end
        end
        r = $urandom_range(0, 99);
        if (r < 10 && !unclosed) begin
            push_byte(CH_BSLASH);
            push_byte(CH_LF);
        end else if (r < 20) begin
            push_byte(CH_NUL);
        end else if (r < 30) begin
            push_byte(pick_blank());
            push_byte(CH_LF);
        end else begin
            push_byte(CH_LF);
        end
    endtask

    initial begin
        logic [LIMIT_BITS-1:0] limits[7];
        int phase_start;
        limits = '{16'd1, 16'd3, 16'd255, 16'd0, 16'hFFFF, 16'd8,
                   LIMIT_BITS'($urandom_range(0, 65535))};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tab separator, quoted word with a blank, empty quoted word, NUL line end,
        // backslash before line end, backslash before a quote, unclosed quote
        send_text("ab\t\"c d\"\n");
        send_text("\"\"");
        push_byte(CH_NUL);
        send_text("x\\\n");
        send_text("\\\"q\" \"u\n");
        settle();

        // plain words vanish at limit 0, the empty quoted word stays
        write_limit('0);
        send_text("ab \"\"\n");
        settle();

        for (int p = 0; p < 7; p++) begin
            write_limit(limits[p]);
            tx_steady = (p == 2 || p == 4);
            rx_steady = (p == 4);
            if (p == 2)
                hold_len = 80;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE)
                send_random_line();
            push_byte(CH_LF);
            settle();
        end

        $display("Sent %0d text bytes and checked %0d results across %0d limit settings,",
                 bytes_sent, sb.checked, limits_used);
        $display("including limits 0 and 65535, escapes, quoted and unclosed words.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
